FILE: rtl/core/pae_page_table_walker_defines.svh
// Assertion macros shared by the page-table walker modules.
`ifndef PAE_PAGE_TABLE_WALKER_DEFINES_SVH
`define PAE_PAGE_TABLE_WALKER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PAE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PAE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pae_ptw_pkg.sv
// Types and constants shared by the page-table walker modules.
package pae_ptw_pkg;

  localparam int unsigned AddrW  = 52;
  localparam int unsigned VaddrW = 32;
  localparam int unsigned EntryW = 64;
  localparam int unsigned PageW  = 12;

  // Input operation codes.
  localparam logic OpTranslate = 1'b0;
  localparam logic OpEntry     = 1'b1;

  // Result kinds.
  localparam logic KindRead = 1'b0;
  localparam logic KindDone = 1'b1;

  // Walk levels: which table entry the walker is waiting for.
  localparam logic [1:0] LvlIdle  = 2'd0;
  localparam logic [1:0] LvlPdpte = 2'd1;
  localparam logic [1:0] LvlPde   = 2'd2;
  localparam logic [1:0] LvlPte   = 2'd3;

  typedef struct packed {
    logic             kind;
    logic [AddrW-1:0] address;
    logic             fault;
  } pae_result_t;

endpackage

FILE: rtl/core/pae_ptw_out_buf.sv
// Two-entry result buffer: an output register backed by one skid register.
`include "pae_page_table_walker_defines.svh"

module pae_ptw_out_buf (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  pae_ptw_pkg::pae_result_t push_data_i,
  output logic                     full_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output pae_ptw_pkg::pae_result_t out_data_o
);
  import pae_ptw_pkg::*;

  logic        out_valid_q;
  logic        skid_valid_q;
  pae_result_t out_q;
  pae_result_t skid_q;
  logic        out_fire;

  assign out_fire = out_valid_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      // The producer is held off while the skid register is occupied.
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= push_data_i;
      end else begin
        out_q <= push_data_i;
      end
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `PAE_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q, "skid holds data ahead of output")
  `PAE_ASSERT_NOW(a_no_push_when_full, skid_valid_q, !push_i, "push while buffer is full")
  `PAE_ASSERT_NEXT(a_stalled_result_kept, out_valid_q && out_stall_i, out_valid_q,
                   "stalled result was lost")

endmodule

FILE: rtl/core/pae_page_table_walker.sv
// Three-level PAE page-table walker: request and entry channel in, read and result channel out.
//
// Usage: the input channel carries either a translate request (op_i low,
// vaddr_i valid) or a table entry returned from memory (op_i high, entry_i
// valid). A request starts a walk, dropping any walk in progress, and
// produces a read of the page directory pointer entry at the table base.
// Each returned entry produces the read of the next level's entry; the
// third (the PTE) produces the finished translation, with fault_o set and
// address_o zero if the PTE faults. An entry that arrives while no walk is
// running is dropped without a result.
// A result is registered in the output buffer before it appears on the output.
// Throughput: one input item per cycle while in_stall_o is low, set by the single
// adder between the input port and the result register.
// A two-entry result buffer lets an item be taken while a result waits;
// in_stall_o rises only once both entries are occupied.
// Reset clears the walk state, the table base and the result buffer.
// The user writes the table base (cfg_we_i / cfg_wdata_i) only while idle; it is not enforced.
`include "pae_page_table_walker_defines.svh"

module pae_page_table_walker #(
  parameter int unsigned PHYS_ADDR_BITS = 52
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pae_ptw_pkg::AddrW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic [pae_ptw_pkg::VaddrW-1:0] vaddr_i,
  input  logic [pae_ptw_pkg::EntryW-1:0] entry_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          kind_o,
  output logic [pae_ptw_pkg::AddrW-1:0] address_o,
  output logic                          fault_o
);
  import pae_ptw_pkg::*;

  localparam int unsigned PaW = PHYS_ADDR_BITS;

  logic [PaW-1:0]    table_base_q;
  logic [1:0]        level_q, level_d;
  logic [VaddrW-1:0] held_vaddr_q, held_vaddr_d;

  logic              in_fire;
  logic              has_result;
  logic              is_last;
  logic              pte_fault;
  logic [PaW-1:0]    sel_base;
  logic [PageW-1:0]  sel_off;
  logic [PaW-1:0]    sum;
  logic              buf_full;
  pae_result_t       res;
  pae_result_t       out_data;

  assign in_stall_o = buf_full;
  assign in_fire    = in_valid_i & ~buf_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_base_q <= '0;
    end else if (cfg_we_i) begin
      table_base_q <= cfg_wdata_i[PaW-1:0];
    end
  end

  // Next read offset and state for the item on the input port.
  always_comb begin
    level_d      = level_q;
    held_vaddr_d = held_vaddr_q;
    sel_base     = {entry_i[PaW-1:PageW], {PageW{1'b0}}};
    sel_off      = '0;
    if (op_i == OpTranslate) begin
      level_d      = LvlPdpte;
      held_vaddr_d = vaddr_i;
      sel_base     = table_base_q;
      sel_off      = {7'd0, vaddr_i[31:30], 3'd0};
    end else begin
      unique case (level_q)
        LvlPdpte: begin
          level_d = LvlPde;
          sel_off = {held_vaddr_q[29:21], 3'd0};
        end
        LvlPde: begin
          level_d = LvlPte;
          sel_off = {held_vaddr_q[20:12], 3'd0};
        end
        LvlPte: begin
          level_d = LvlIdle;
          sel_off = held_vaddr_q[11:0];
        end
        default: begin
          level_d = LvlIdle;
        end
      endcase
    end
  end

  assign sum        = sel_base + PaW'(sel_off);
  assign has_result = (op_i == OpTranslate) || (level_q != LvlIdle);
  assign is_last    = (op_i == OpEntry) && (level_q == LvlPte);

  // A PTE faults if dirty without both writable and accessed, or if bit 7
  // or the user bit is set.
  assign pte_fault = (entry_i[6] & ~(entry_i[1] & entry_i[5])) | entry_i[7] | entry_i[2];

  always_comb begin
    res.kind    = is_last ? KindDone : KindRead;
    res.fault   = is_last & pte_fault;
    res.address = res.fault ? '0 : AddrW'(sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q      <= LvlIdle;
      held_vaddr_q <= '0;
    end else if (in_fire) begin
      level_q      <= level_d;
      held_vaddr_q <= held_vaddr_d;
    end
  end

  pae_ptw_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire & has_result),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign kind_o    = out_data.kind;
  assign address_o = out_data.address;
  assign fault_o   = out_data.fault;

  `PAE_ASSERT_NEXT(a_request_starts_walk, in_fire && (op_i == OpTranslate),
                   level_q == LvlPdpte, "translate request did not start a walk")
  `PAE_ASSERT_NEXT(a_idle_entry_ignored, in_fire && (op_i == OpEntry) && (level_q == LvlIdle),
                   level_q == LvlIdle, "entry while idle changed the walk level")
  `PAE_ASSERT_NOW(a_fault_only_when_done, out_valid_o && fault_o, kind_o == KindDone,
                  "fault reported on a read request")

endmodule
